### sv/dspp_pkg.sv
// ----------------------------------------------------------------------------
// dspp_pkg
// Types and constants for the dip schedule position profile.
// ----------------------------------------------------------------------------
package dspp_pkg;

  localparam int HEIGHT_W  = 20;
  localparam int TIME_W    = 28;
  localparam int OUT_W     = 28;
  localparam int PHASE_W   = 3;
  localparam int CFG_W     = 28;
  localparam int CFG_IDX_W = 3;
  localparam int DIP_SLOTS = 4;   // dip table size; slots past the registers read 0
  localparam int CFG_DIPS  = 3;   // dips backed by registers
  localparam int ROOT_W    = 15;  // width of the triangle ramp time
  localparam int NN_W      = 19;
  localparam int CX_W      = 30;

  localparam logic [OUT_W-1:0] AFTER_HEIGHT = 28'd2560000;
  localparam logic [23:0]      TRAP_LIMIT   = 24'd163840;
  localparam logic [25:0]      RAMP_TICKS   = 26'd262144;
  localparam logic [CX_W-1:0]  CRUISE_OFS   = 30'd4194303;
  localparam logic [31:0]      RECIP_3      = 32'hAAAAAAAB;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_0    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_1    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END_2    = 3'd5;

  typedef enum logic [PHASE_W-1:0] {
    PH_HOLD   = 3'd0,
    PH_ACCEL  = 3'd1,
    PH_CRUISE = 3'd2,
    PH_DECEL  = 3'd3,
    PH_AFTER  = 3'd4
  } phase_t;

  // request payload while the ramp time is being searched
  typedef struct packed {
    logic                after;
    logic                hold;
    logic                up;
    logic                trap;
    phase_t              ph;
    logic [HEIGHT_W-1:0] start;
    logic [HEIGHT_W-1:0] d;
    logic [TIME_W-1:0]   dt;
    logic [NN_W-1:0]     nn;
    logic [CX_W-1:0]     cx;
  } pipe_t;

  // request payload in the back end
  typedef struct packed {
    logic                after;
    logic                hold;
    logic                up;
    logic                trap;
    phase_t              ph;
    logic [HEIGHT_W-1:0] start;
    logic [HEIGHT_W-1:0] d;
  } tail_t;

endpackage

### sv/dip_schedule_position_profile.sv
// ----------------------------------------------------------------------------
// dip_schedule_position_profile
// Commanded height of a dip schedule at a query time, trapezoid/triangle moves.
// ----------------------------------------------------------------------------
// Takes one query per clock (busy is always low) and gives its result on
// out_valid, for exactly one cycle; the receiver cannot hold results off.
// The pipeline has four front stages (input, segment select, distance,
// trapezoid phase), fifteen stages of the bit-per-stage search for the
// triangle ramp time, then five stages of final phase, squaring, scaling,
// division by three and the final add.
// Configuration must be written only while no request is in flight; the
// pipeline reads the live registers.
module dip_schedule_position_profile #(
  parameter int NUM_DIPS = 3
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [dspp_pkg::TIME_W-1:0]    in_query_time,
  output logic                           out_valid,
  output logic [dspp_pkg::OUT_W-1:0]     out_commanded_height,
  output logic [dspp_pkg::PHASE_W-1:0]   out_segment_phase,
  input  logic                           cfg_we,
  input  logic [dspp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dspp_pkg::CFG_W-1:0]     cfg_data
);
  import dspp_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [HEIGHT_W-1:0] height_r [CFG_DIPS];
  logic [TIME_W-1:0]   end_r    [CFG_DIPS];
  logic [HEIGHT_W-1:0] height_w [DIP_SLOTS];
  logic [TIME_W-1:0]   end_w    [DIP_SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CFG_DIPS; i++) begin
        height_r[i] <= '0;
        end_r[i]    <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEIGHT_0: height_r[0] <= cfg_data[HEIGHT_W-1:0];
        REG_HEIGHT_1: height_r[1] <= cfg_data[HEIGHT_W-1:0];
        REG_HEIGHT_2: height_r[2] <= cfg_data[HEIGHT_W-1:0];
        REG_END_0:    end_r[0]    <= cfg_data;
        REG_END_1:    end_r[1]    <= cfg_data;
        REG_END_2:    end_r[2]    <= cfg_data;
        default: ;   // unknown index: ignored
      endcase
    end
  end

  // dips past the registered ones read as height 0, end 0
  always_comb begin
    for (int i = 0; i < DIP_SLOTS; i++) begin
      if (i < CFG_DIPS) begin
        height_w[i] = height_r[i];
        end_w[i]    = end_r[i];
      end else begin
        height_w[i] = '0;
        end_w[i]    = '0;
      end
    end
  end

  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // Stage 1: input register
  // --------------------------------------------------------------------------
  logic              s1_vld_r;
  logic [TIME_W-1:0] s1_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= start & ~busy;
    s1_t_r <= in_query_time;
  end

  // --------------------------------------------------------------------------
  // Stage 2: segment select. First dip whose end lies beyond t wins.
  // --------------------------------------------------------------------------
  logic                s2_vld_r, s2_after_r, s2_hold_r;
  logic [HEIGHT_W-1:0] s2_start_r, s2_target_r;
  logic [TIME_W-1:0]   s2_pend_r, s2_t_r;
  logic                s2_after_nxt, s2_hold_nxt;
  logic [HEIGHT_W-1:0] s2_start_nxt, s2_target_nxt;
  logic [TIME_W-1:0]   s2_pend_nxt;

  always_comb begin
    s2_after_nxt  = s1_t_r >= end_w[NUM_DIPS-1];
    s2_hold_nxt   = end_w[0] > s1_t_r;
    s2_start_nxt  = '0;
    s2_target_nxt = '0;
    s2_pend_nxt   = '0;
    for (int i = NUM_DIPS - 1; i >= 1; i--) begin
      if (end_w[i] > s1_t_r) begin
        s2_start_nxt  = height_w[i-1];
        s2_target_nxt = height_w[i];
        s2_pend_nxt   = end_w[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
    s2_after_r  <= s2_after_nxt;
    s2_hold_r   <= s2_hold_nxt;
    s2_start_r  <= s2_start_nxt;
    s2_target_r <= s2_target_nxt;
    s2_pend_r   <= s2_pend_nxt;
    s2_t_r      <= s1_t_r;
  end

  // --------------------------------------------------------------------------
  // Stage 3: move distance, direction and time into the move
  // --------------------------------------------------------------------------
  logic                s3_vld_r, s3_after_r, s3_hold_r, s3_up_r;
  logic [HEIGHT_W-1:0] s3_start_r, s3_d_r;
  logic [TIME_W-1:0]   s3_dt_r;
  logic                s3_up_nxt;

  assign s3_up_nxt = s2_target_r >= s2_start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else        s3_vld_r <= s2_vld_r;
    s3_after_r <= s2_after_r;
    s3_hold_r  <= s2_hold_r;
    s3_up_r    <= s3_up_nxt;
    s3_start_r <= s2_start_r;
    s3_d_r     <= s3_up_nxt ? s2_target_r - s2_start_r : s2_start_r - s2_target_r;
    s3_dt_r    <= s2_t_r - s2_pend_r;
  end

  // --------------------------------------------------------------------------
  // Stage 4: trapezoid phase, decel remainder, cruise numerator.
  // Feeds the root search array at slot 0.
  // --------------------------------------------------------------------------
  logic        sp_vld_r [ROOT_W+1];
  pipe_t       sp_r     [ROOT_W+1];
  logic [ROOT_W-1:0] root_r [ROOT_W+1];
  logic [29:0]       rsq_r  [ROOT_W+1];

  logic [31:0] a_w;      // 15*dt
  logic [24:0] lim_w;    // 24*D
  logic [25:0] lim2_w;   // 24*D + ramp
  logic [31:0] nn_w;
  pipe_t       s4_nxt;

  assign a_w    = {4'd0, s3_dt_r} * 32'd15;
  assign lim_w  = {5'd0, s3_d_r} * 25'd24;
  assign lim2_w = {1'b0, lim_w} + RAMP_TICKS;
  assign nn_w   = {6'd0, lim2_w} - a_w;

  always_comb begin
    s4_nxt       = '0;
    s4_nxt.after = s3_after_r;
    s4_nxt.hold  = s3_hold_r;
    s4_nxt.up    = s3_up_r;
    s4_nxt.trap  = ({4'd0, s3_d_r} * 24'd15) > TRAP_LIMIT;
    s4_nxt.start = s3_start_r;
    s4_nxt.d     = s3_d_r;
    s4_nxt.dt    = s3_dt_r;
    s4_nxt.nn    = nn_w[NN_W-1:0];
    // valid only in cruise, where dt is below 1.6*D
    s4_nxt.cx    = 30'({9'd0, s3_dt_r[20:0]} * 30'd480) - CRUISE_OFS;
    if (a_w < {6'd0, RAMP_TICKS})    s4_nxt.ph = PH_ACCEL;
    else if (a_w < {7'd0, lim_w})    s4_nxt.ph = PH_CRUISE;
    else if (a_w < {6'd0, lim2_w})   s4_nxt.ph = PH_DECEL;
    else                             s4_nxt.ph = PH_HOLD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sp_vld_r[0] <= 1'b0;
    else        sp_vld_r[0] <= s3_vld_r;
    sp_r[0]   <= s4_nxt;
    root_r[0] <= '0;
    rsq_r[0]  <= '0;
  end

  // --------------------------------------------------------------------------
  // Triangle ramp time: largest Th with 75*Th^2 <= D*2^21, one bit per stage,
  // square kept alongside so each stage is a shift-add and a compare.
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    localparam int B = ROOT_W - 1 - k;
    logic [ROOT_W-1:0] cand;
    logic [29:0]       cand_sq;
    logic [41:0]       lhs, rhs;

    assign cand    = root_r[k] | (ROOT_W'(1) << B);
    assign cand_sq = rsq_r[k] + (30'(root_r[k]) << (B + 1)) + (30'(1) << (2 * B));
    assign lhs     = {12'd0, cand_sq} * 42'd75;
    assign rhs     = {1'b0, sp_r[k].d, 21'd0};

    always_ff @(posedge clk) begin
      if (!rst_n) sp_vld_r[k+1] <= 1'b0;
      else        sp_vld_r[k+1] <= sp_vld_r[k];
      sp_r[k+1] <= sp_r[k];
      if (lhs <= rhs) begin
        root_r[k+1] <= cand;
        rsq_r[k+1]  <= cand_sq;
      end else begin
        root_r[k+1] <= root_r[k];
        rsq_r[k+1]  <= rsq_r[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: final phase and square operand
  // --------------------------------------------------------------------------
  pipe_t             pe;
  logic [ROOT_W-1:0] th;
  logic [ROOT_W:0]   th2;
  logic              s5_vld_r;
  tail_t             s5_r;
  logic [NN_W-1:0]   s5_op_r;
  logic [CX_W-1:0]   s5_cx_r;
  tail_t             s5_nxt;
  logic [NN_W-1:0]   s5_op_nxt;
  logic [ROOT_W:0]   r_w;

  assign pe  = sp_r[ROOT_W];
  assign th  = root_r[ROOT_W];
  assign th2 = {th, 1'b0};
  assign r_w = th2 - pe.dt[ROOT_W:0];

  always_comb begin
    s5_nxt.after = pe.after;
    s5_nxt.hold  = pe.hold;
    s5_nxt.up    = pe.up;
    s5_nxt.trap  = pe.trap;
    s5_nxt.start = pe.start;
    s5_nxt.d     = pe.d;
    s5_nxt.ph    = PH_HOLD;
    s5_op_nxt    = {4'd0, pe.dt[ROOT_W-1:0]};
    if (pe.trap) begin
      s5_nxt.ph = pe.ph;
      if (pe.ph == PH_DECEL) s5_op_nxt = pe.nn;
    end else if (pe.dt < {13'd0, th}) begin
      s5_nxt.ph = PH_ACCEL;
    end else if (pe.dt < {12'd0, th2}) begin
      s5_nxt.ph = PH_DECEL;
      s5_op_nxt = {4'd0, r_w[ROOT_W-1:0]};   // r never exceeds Th
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s5_vld_r <= 1'b0;
    else        s5_vld_r <= sp_vld_r[ROOT_W];
    s5_r    <= s5_nxt;
    s5_op_r <= s5_op_nxt;
    s5_cx_r <= pe.cx;
  end

  // --------------------------------------------------------------------------
  // Stage 6: square, cruise divide by three
  // --------------------------------------------------------------------------
  logic        s6_vld_r;
  tail_t       s6_r;
  logic [37:0] s6_sq_r;
  logic [28:0] s6_cq_r;
  logic [61:0] cprod_w;

  assign cprod_w = {32'd0, s5_cx_r} * {30'd0, RECIP_3};

  always_ff @(posedge clk) begin
    if (!rst_n) s6_vld_r <= 1'b0;
    else        s6_vld_r <= s5_vld_r;
    s6_r    <= s5_r;
    s6_sq_r <= {19'd0, s5_op_r} * {19'd0, s5_op_r};
    s6_cq_r <= cprod_w[61:33];
  end

  // --------------------------------------------------------------------------
  // Stage 7: ramp scaling (75/16384, rounded) and decel remainder / 16384
  // --------------------------------------------------------------------------
  logic        s7_vld_r;
  tail_t       s7_r;
  logic [27:0] s7_amag_r;
  logic [24:0] s7_y_r;
  logic [28:0] s7_cq_r;
  logic [44:0] amag_w;
  logic [38:0] y_w;

  assign amag_w = {7'd0, s6_sq_r} * 45'd75 + 45'd8192;
  assign y_w    = {1'b0, s6_sq_r} + 39'd24576;

  always_ff @(posedge clk) begin
    if (!rst_n) s7_vld_r <= 1'b0;
    else        s7_vld_r <= s6_vld_r;
    s7_r      <= s6_r;
    s7_amag_r <= amag_w[41:14];   // only ramp squares reach here, well below 2^28
    s7_y_r    <= y_w[38:14];
    s7_cq_r   <= s6_cq_r;
  end

  // --------------------------------------------------------------------------
  // Stage 8: magnitude, clamped between zero and the full move
  // --------------------------------------------------------------------------
  logic              s8_vld_r;
  tail_t             s8_r;
  logic [OUT_W-1:0]  s8_mag_r;
  logic [OUT_W-1:0]  full_w, sub_w, mag_nxt;
  logic [56:0]       yprod_w;

  assign full_w  = {s7_r.d, 8'd0};
  assign yprod_w = {32'd0, s7_y_r} * {25'd0, RECIP_3};

  always_comb begin
    sub_w = s7_r.trap ? {4'd0, yprod_w[56:33]} : s7_amag_r;
    unique case (s7_r.ph)
      PH_ACCEL:  mag_nxt = (s7_amag_r > full_w) ? full_w : s7_amag_r;
      PH_CRUISE: mag_nxt = (s7_cq_r > {1'b0, full_w}) ? full_w
                                                     : s7_cq_r[OUT_W-1:0];
      PH_DECEL:  mag_nxt = (sub_w > full_w) ? '0 : full_w - sub_w;
      default:   mag_nxt = full_w;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s8_vld_r <= 1'b0;
    else        s8_vld_r <= s7_vld_r;
    s8_r     <= s7_r;
    s8_mag_r <= mag_nxt;
  end

  // --------------------------------------------------------------------------
  // Output register: move result, or the hold / after-schedule cases
  // --------------------------------------------------------------------------
  logic             out_vld_r;
  logic [OUT_W-1:0] out_h_r;
  phase_t           out_ph_r;
  logic [OUT_W-1:0] base_w, h_nxt;
  phase_t           ph_nxt;

  assign base_w = {s8_r.start, 8'd0};

  always_comb begin
    if (s8_r.after) begin
      h_nxt  = AFTER_HEIGHT;
      ph_nxt = PH_AFTER;
    end else if (s8_r.hold) begin
      h_nxt  = {height_w[0], 8'd0};
      ph_nxt = PH_HOLD;
    end else begin
      h_nxt  = s8_r.up ? base_w + s8_mag_r : base_w - s8_mag_r;
      ph_nxt = s8_r.ph;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else        out_vld_r <= s8_vld_r;
    out_h_r  <= h_nxt;
    out_ph_r <= ph_nxt;
  end

  assign out_valid            = out_vld_r;
  assign out_commanded_height = out_h_r;
  assign out_segment_phase    = out_ph_r;

endmodule
